[rtl/clh_pkg.sv]
// ----------------------------------------------------------------------------
// clh_pkg
// Shared types and constants of the classifier loss and gradient head.
// ----------------------------------------------------------------------------
package clh_pkg;

    localparam int unsigned ONE_Q12      = 4096;
    localparam int unsigned LN2_Q16      = 45426;
    localparam int unsigned ROW_LOSS_MAX = 331776;
    localparam int unsigned DIV_STEPS    = 28;
    localparam int unsigned LOG_STEPS    = 16;

    localparam logic [7:0] CFG_LOSS_MODE   = 8'd0;
    localparam logic [7:0] CFG_NUM_CLASSES = 8'd1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PREP,
        ST_DIV,
        ST_LOG,
        ST_LMUL,
        ST_FIN
    } t_state;

    // controller -> datapath
    typedef struct packed {
        logic accept;
        logic prep;
        logic div_step;
        logic log_step;
        logic lmul;
        logic fin;
    } t_cmd;

    // datapath -> controller
    typedef struct packed {
        logic row_end;
        logic ce;
        logic iter_last;
        logic out_free;
    } t_sts;

endpackage

[rtl/clh_ctrl.sv]
// ----------------------------------------------------------------------------
// clh_ctrl
// Sequencer: item accept, row-end divide or log iterations, result write.
// ----------------------------------------------------------------------------
module clh_ctrl
    import clh_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_valid,
    output logic o_ready,
    input  t_sts i_sts,
    output t_cmd o_cmd
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        o_ready = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                o_ready = i_sts.out_free;
                if (i_valid && i_sts.out_free) begin
                    o_cmd.accept = 1'b1;
                    if (i_sts.row_end) begin
                        n_state = ST_PREP;
                    end
                end
            end
            ST_PREP: begin
                o_cmd.prep = 1'b1;
                n_state    = i_sts.ce ? ST_LOG : ST_DIV;
            end
            ST_DIV: begin
                o_cmd.div_step = 1'b1;
                if (i_sts.iter_last) begin
                    n_state = ST_FIN;
                end
            end
            ST_LOG: begin
                o_cmd.log_step = 1'b1;
                if (i_sts.iter_last) begin
                    n_state = ST_LMUL;
                end
            end
            ST_LMUL: begin
                o_cmd.lmul = 1'b1;
                n_state    = ST_FIN;
            end
            ST_FIN: begin
                if (i_sts.out_free) begin
                    o_cmd.fin = 1'b1;
                    n_state   = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

endmodule

[rtl/clh_dp.sv]
// ----------------------------------------------------------------------------
// clh_dp
// Datapath: gradient, argmax, row accumulator, serial divider, log unit,
// batch totals and the output register.
// ----------------------------------------------------------------------------
module clh_dp
    import clh_pkg::*;
#(
    parameter int MAX_CLASSES = 256,
    parameter int MAX_BATCH   = 65536
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_cmd               i_cmd,
    output t_sts               o_sts,
    input  logic               i_cfg_we,
    input  logic [7:0]         i_cfg_index,
    input  logic [8:0]         i_cfg_data,
    input  logic signed [15:0] i_score,
    input  logic [7:0]         i_label,
    input  logic               i_first_in_batch,
    input  logic               i_out_ready,
    output logic               o_out_valid,
    output logic signed [16:0] o_gradient,
    output logic               o_row_done,
    output logic [18:0]        o_row_loss,
    output logic [7:0]         o_predicted_class,
    output logic               o_correct,
    output logic [34:0]        o_batch_loss_total,
    output logic [16:0]        o_correct_count
);

    localparam logic [34:0] LOSS_CAP = 35'(longint'(MAX_BATCH) * longint'(ROW_LOSS_MAX));
    localparam logic [16:0] HIT_CAP  = 17'(MAX_BATCH);
    localparam logic [8:0]  N_MAX    = 9'(MAX_CLASSES);
    localparam logic [27:0] RL_MAX   = 28'(ROW_LOSS_MAX);

    logic               r_loss_mode;
    logic [8:0]         r_num_classes;
    logic [7:0]         r_pos;
    logic [7:0]         r_best_idx;
    logic signed [15:0] r_best_score;
    logic [39:0]        r_acc;
    logic [34:0]        r_total;
    logic [16:0]        r_hits;
    logic signed [16:0] r_grad;
    logic [7:0]         r_pred;
    logic               r_corr;
    logic               r_ce;
    logic [8:0]         r_rem;
    logic [27:0]        r_dq;
    logic [4:0]         r_cnt;
    logic [15:0]        r_y;
    logic [15:0]        r_frac;
    logic [3:0]         r_e;
    logic               r_ce_zero;
    logic [18:0]        r_row_loss;
    logic               r_ov;
    logic               n_ov;

    // per-item logic
    logic [8:0]         n_eff;
    logic               hot;
    logic signed [16:0] target;
    logic signed [16:0] grad;
    logic signed [16:0] tdiff;
    logic signed [33:0] sq;
    logic [39:0]        acc_base;
    logic [39:0]        acc_new;
    logic               row_end;
    logic [7:0]         best_idx_new;
    logic signed [15:0] best_score_new;
    logic [34:0]        tot_c;
    logic [16:0]        hits_c;
    logic               corr_new;
    logic               out_free;

    // row-end logic
    logic [14:0] x;
    logic [11:0] x12;
    logic [3:0]  e;
    logic [9:0]  rem_sh;
    logic        rem_ge;
    logic [9:0]  rem_nx;
    logic [31:0] ysq;
    logic [16:0] yt;
    logic [19:0] lval;
    logic [35:0] prod;
    logic [18:0] rl;
    logic [35:0] tot_sum;
    logic [34:0] tot_new;
    logic [16:0] hits_new;

    assign out_free = !r_ov || i_out_ready;

    always_comb begin
        n_ov = r_ov && !i_out_ready;
        if ((i_cmd.accept && !row_end) || i_cmd.fin) begin
            n_ov = 1'b1;
        end
    end

    always_comb begin
        n_eff = r_num_classes;
        if (n_eff == 9'd0) begin
            n_eff = 9'd1;
        end else if (n_eff > N_MAX) begin
            n_eff = N_MAX;
        end
        hot    = (r_pos == i_label);
        target = hot ? 17'(ONE_Q12) : 17'sd0;
        grad   = 17'(i_score) - target;
        tdiff  = target - 17'(i_score);
        sq     = 34'(tdiff) * 34'(tdiff);
        acc_base = (r_pos == 8'd0) ? 40'd0 : r_acc;
        if (!r_loss_mode) begin
            acc_new = acc_base + 40'(sq[30:0]);
        end else if (hot) begin
            acc_new = (i_score < 16'sd1) ? 40'd1 : 40'(i_score[14:0]);
        end else begin
            acc_new = acc_base;
        end
        if (r_pos == 8'd0 || i_score > r_best_score) begin
            best_idx_new   = r_pos;
            best_score_new = i_score;
        end else begin
            best_idx_new   = r_best_idx;
            best_score_new = r_best_score;
        end
        row_end  = ({1'b0, r_pos} + 9'd1) >= n_eff;
        corr_new = (best_idx_new == i_label);
        tot_c    = i_first_in_batch ? 35'd0 : r_total;
        hits_c   = i_first_in_batch ? 17'd0 : r_hits;
    end

    always_comb begin
        if (r_acc == 40'd0) begin
            x = 15'd1;
        end else if (r_acc > 40'd32767) begin
            x = 15'd32767;
        end else begin
            x = r_acc[14:0];
        end
        x12 = x[11:0];
        e   = 4'd0;
        for (int i = 0; i < 12; i++) begin
            if (x12[i]) begin
                e = 4'(i);
            end
        end
        rem_sh = {r_rem, r_dq[27]};
        rem_ge = rem_sh >= {1'b0, n_eff};
        rem_nx = rem_ge ? rem_sh - {1'b0, n_eff} : rem_sh;
        ysq    = 32'(r_y) * 32'(r_y);
        yt     = ysq[31:15];
        lval   = {4'd12 - r_e, 16'd0} - {4'd0, r_frac};
        prod   = 36'(lval) * 36'(LN2_Q16);
        if (r_ce) begin
            rl = r_row_loss;
        end else if (r_dq > RL_MAX) begin
            rl = RL_MAX[18:0];
        end else begin
            rl = r_dq[18:0];
        end
        tot_sum  = {1'b0, r_total} + 36'(rl);
        tot_new  = (tot_sum > {1'b0, LOSS_CAP}) ? LOSS_CAP : tot_sum[34:0];
        hits_new = (r_corr && r_hits < HIT_CAP) ? r_hits + 17'd1 : r_hits;
    end

    assign o_sts.row_end   = row_end;
    assign o_sts.ce        = r_ce;
    assign o_sts.iter_last = (r_cnt == 5'd0);
    assign o_sts.out_free  = out_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_loss_mode   <= 1'b0;
            r_num_classes <= 9'd10;
            r_pos         <= '0;
            r_best_idx    <= '0;
            r_best_score  <= '0;
            r_acc         <= '0;
            r_total       <= '0;
            r_hits        <= '0;
            r_ov          <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_index == CFG_LOSS_MODE) begin
                    r_loss_mode <= i_cfg_data[0];
                end else if (i_cfg_index == CFG_NUM_CLASSES) begin
                    r_num_classes <= i_cfg_data;
                end
            end
            r_ov <= n_ov;
            if (i_cmd.accept) begin
                r_pos        <= row_end ? 8'd0 : r_pos + 8'd1;
                r_best_idx   <= best_idx_new;
                r_best_score <= best_score_new;
                r_acc        <= acc_new;
                r_total      <= tot_c;
                r_hits       <= hits_c;
            end
            if (i_cmd.fin) begin
                r_total <= tot_new;
                r_hits  <= hits_new;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_grad <= grad;
            r_pred <= best_idx_new;
            r_corr <= corr_new;
            r_ce   <= r_loss_mode;
            if (!row_end) begin
                o_gradient         <= grad;
                o_row_done         <= 1'b0;
                o_row_loss         <= '0;
                o_predicted_class  <= '0;
                o_correct          <= 1'b0;
                o_batch_loss_total <= tot_c;
                o_correct_count    <= hits_c;
            end
        end
        if (i_cmd.prep) begin
            r_rem     <= '0;
            r_dq      <= r_acc[39:12];
            r_cnt     <= r_ce ? 5'(LOG_STEPS - 1) : 5'(DIV_STEPS - 1);
            r_y       <= 16'({4'd0, x12} << (4'd15 - e));
            r_frac    <= '0;
            r_e       <= e;
            r_ce_zero <= (x >= 15'(ONE_Q12));
        end
        if (i_cmd.div_step) begin
            r_rem <= rem_nx[8:0];
            r_dq  <= {r_dq[26:0], rem_ge};
            r_cnt <= r_cnt - 5'd1;
        end
        if (i_cmd.log_step) begin
            r_y    <= yt[16] ? yt[16:1] : yt[15:0];
            r_frac <= {r_frac[14:0], yt[16]};
            r_cnt  <= r_cnt - 5'd1;
        end
        if (i_cmd.lmul) begin
            r_row_loss <= r_ce_zero ? 19'd0 : {3'd0, prod[35:20]};
        end
        if (i_cmd.fin) begin
            o_gradient         <= r_grad;
            o_row_done         <= 1'b1;
            o_row_loss         <= rl;
            o_predicted_class  <= r_pred;
            o_correct          <= r_corr;
            o_batch_loss_total <= tot_new;
            o_correct_count    <= hits_new;
        end
    end

    assign o_out_valid = r_ov;

    a_hits_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_hits <= HIT_CAP) else $error("hit count above cap");
    a_loss_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_total <= LOSS_CAP) else $error("loss total above cap");
    a_fin_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.fin |-> out_free) else $error("result written over a pending item");
    a_row_loss: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.fin |=> o_row_loss <= 19'(ROW_LOSS_MAX)) else $error("row loss out of range");

endmodule

[rtl/classifier_loss_gradient_head.sv]
// ----------------------------------------------------------------------------
// classifier_loss_gradient_head
// Per-score gradient, row argmax, row loss (MSE or cross entropy), batch totals.
// ----------------------------------------------------------------------------
// Scores arrive one item per handshake, row by row, with the row's label.
// Every item yields one result item: gradient score minus one-hot target,
// and on the last score of a row (tlast) also the row loss, predicted
// class and correct flag; every item carries the saturating batch totals.
// A score that does not end a row is written straight into the result register.
// A row-end score starts the row-end unit, and no new score is taken until it
// is done: mean squared error runs a 28-step bit-serial divide by the class
// count; cross entropy runs a 16-step squaring log2 loop plus one multiply by ln 2.
// One result register sits on the output; a new item is taken while the
// previous result is being drained. num_classes 0 acts as 1.
// Config port: index 0 loss_mode, index 1 num_classes; write only when idle.
// ----------------------------------------------------------------------------
module classifier_loss_gradient_head
    import clh_pkg::*;
#(
    parameter int MAX_CLASSES = 256,
    parameter int MAX_BATCH   = 65536
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    // config write channel
    input  logic         i_cfg_valid,
    output logic         o_cfg_ready,
    input  logic [7:0]   i_cfg_index,
    input  logic [8:0]   i_cfg_data,
    // score input
    input  logic         i_s_axis_tvalid,
    output logic         o_s_axis_tready,
    input  logic [23:0]  i_s_axis_tdata,  // score[15:0], label[23:16]
    input  logic         i_s_axis_tuser,  // first_in_batch
    // result output
    output logic         o_m_axis_tvalid,
    input  logic         i_m_axis_tready,
    output logic [103:0] o_m_axis_tdata,  // gradient[16:0], row_loss[35:17],
                                          // predicted_class[43:36], correct[44],
                                          // batch_loss_total[79:45],
                                          // correct_count[96:80], zero pad
    output logic         o_m_axis_tlast   // row_done
);

    t_cmd               cmd;
    t_sts               sts;
    logic signed [16:0] gradient;
    logic               row_done;
    logic [18:0]        row_loss;
    logic [7:0]         predicted_class;
    logic               correct;
    logic [34:0]        batch_loss_total;
    logic [16:0]        correct_count;

    assign o_cfg_ready = 1'b1;

    clh_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_s_axis_tvalid),
        .o_ready (o_s_axis_tready),
        .i_sts   (sts),
        .o_cmd   (cmd)
    );

    clh_dp #(
        .MAX_CLASSES (MAX_CLASSES),
        .MAX_BATCH   (MAX_BATCH)
    ) u_dp (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cmd              (cmd),
        .o_sts              (sts),
        .i_cfg_we           (i_cfg_valid),
        .i_cfg_index        (i_cfg_index),
        .i_cfg_data         (i_cfg_data),
        .i_score            (i_s_axis_tdata[15:0]),
        .i_label            (i_s_axis_tdata[23:16]),
        .i_first_in_batch   (i_s_axis_tuser),
        .i_out_ready        (i_m_axis_tready),
        .o_out_valid        (o_m_axis_tvalid),
        .o_gradient         (gradient),
        .o_row_done         (row_done),
        .o_row_loss         (row_loss),
        .o_predicted_class  (predicted_class),
        .o_correct          (correct),
        .o_batch_loss_total (batch_loss_total),
        .o_correct_count    (correct_count)
    );

    assign o_m_axis_tdata = {7'd0, correct_count, batch_loss_total, correct,
                             predicted_class, row_loss, gradient};
    assign o_m_axis_tlast = row_done;

endmodule

[bench/clh_checker.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// clh_checker
// Watches the config, score and result channels of the loss/gradient head,
// predicts every result item and compares it field by field.
// ----------------------------------------------------------------------------
module clh_checker
    import clh_pkg::*;
(
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_cfg_valid,
    input  logic         i_cfg_ready,
    input  logic [7:0]   i_cfg_index,
    input  logic [8:0]   i_cfg_data,
    input  logic         i_s_valid,
    input  logic         i_s_ready,
    input  logic [23:0]  i_s_data,     // score[15:0], label[23:16]
    input  logic         i_s_user,     // first_in_batch
    input  logic         i_m_valid,
    input  logic         i_m_ready,
    input  logic [103:0] i_m_data,
    input  logic         i_m_last,     // row_done
    output int           o_errors,
    output int           o_pending
);

    localparam longint unsigned LOSS_CAP = 64'd65536 * ROW_LOSS_MAX;
    localparam int unsigned     HIT_CAP  = 65536;

    typedef struct packed {
        logic [16:0] gradient;
        logic        row_done;
        logic [18:0] row_loss;
        logic [7:0]  pred;
        logic        correct;
        logic [34:0] loss_total;
        logic [16:0] hits;
    } t_result;

    t_result result_q[$];

    // shadow config and row state
    logic        mode_sh;
    logic [8:0]  ncls_sh;
    logic [7:0]  position;
    logic [7:0]  best_idx;
    int          best_val;
    logic [39:0] row_acc;
    longint unsigned total_sh;
    int unsigned hits_sh;

    initial o_errors = 0;
    assign o_pending = result_q.size();

    // -ln(x/4096) in Q12, x in 1..4095, via squaring log2
    function automatic logic [18:0] neg_ln(int unsigned x);
        int unsigned     e;
        int unsigned     frac;
        longint unsigned y;
        longint unsigned lq;
        e = 0;
        frac = 0;
        while (e < 15 && (x >> (e + 1)) != 0) e++;
        y = longint'(x) << (15 - e);
        for (int i = 0; i < 16; i++) begin
            y = (y * y) >> 15;
            frac = frac << 1;
            if (y >= 65536) begin
                y = y >> 1;
                frac = frac | 1;
            end
        end
        lq = (longint'(12 - e) << 16) - frac;
        return 19'((lq * LN2_Q16) >> 20);
    endfunction

    function automatic t_result predict_score(logic [15:0] raw, logic [7:0] lab, logic first);
        t_result     r;
        int          s;
        int          n;
        int          target;
        int          t;
        logic        hot;
        longint unsigned l;
        longint unsigned x;
        s = int'($signed(raw));
        n = (ncls_sh == 0) ? 1 : (ncls_sh > 256) ? 256 : int'(ncls_sh);
        hot = (position == lab);
        target = hot ? ONE_Q12 : 0;
        r = '0;
        if (first) begin
            total_sh = 0;
            hits_sh = 0;
        end
        r.gradient = 17'(s - target);
        if (position == 0) begin
            row_acc = '0;
            best_idx = '0;
            best_val = s;
        end else if (s > best_val) begin
            best_idx = position;
            best_val = s;
        end
        if (mode_sh == 1'b0) begin
            t = target - s;
            row_acc = row_acc + 40'(longint'(t) * t);
        end else if (hot) begin
            row_acc = 40'((s < 1) ? 1 : s);
        end
        if (int'(position) + 1 >= n) begin
            r.row_done = 1'b1;
            if (mode_sh == 1'b0) begin
                l = (longint'(row_acc) >> 12) / n;
                r.row_loss = 19'((l > ROW_LOSS_MAX) ? ROW_LOSS_MAX : l);
            end else begin
                x = row_acc;
                if (x < 1) x = 1;
                if (x > 32767) x = 32767;
                r.row_loss = (x >= ONE_Q12) ? 19'd0 : neg_ln(int'(x));
            end
            r.pred = best_idx;
            r.correct = (best_idx == lab);
            total_sh = total_sh + r.row_loss;
            if (total_sh > LOSS_CAP) total_sh = LOSS_CAP;
            if (r.correct && hits_sh < HIT_CAP) hits_sh++;
            position = '0;
        end else begin
            position = position + 8'd1;
        end
        r.loss_total = 35'(total_sh);
        r.hits = 17'(hits_sh);
        return r;
    endfunction

    always @(posedge i_clk) begin
        t_result got;
        t_result exp_r;
        if (!i_rst_n) begin
            mode_sh <= 1'b0;
            ncls_sh <= 9'd10;
            position = '0;
            best_idx = '0;
            best_val = 0;
            row_acc = '0;
            total_sh = 0;
            hits_sh = 0;
            result_q.delete();
        end else begin
            // results first: a result can never belong to an item taken this edge
            if (i_m_valid && i_m_ready) begin
                got.gradient   = i_m_data[16:0];
                got.row_done   = i_m_last;
                got.row_loss   = i_m_data[35:17];
                got.pred       = i_m_data[43:36];
                got.correct    = i_m_data[44];
                got.loss_total = i_m_data[79:45];
                got.hits       = i_m_data[96:80];
                if (result_q.size() == 0) begin
                    $display("%0t: unexpected result item %h", $time, got);
                    o_errors <= o_errors + 1;
                end else begin
                    exp_r = result_q.pop_front();
                    if (got !== exp_r) begin
                        o_errors <= o_errors + 1;
                        if (got.gradient !== exp_r.gradient)
                            $display("%0t: gradient exp %h got %h", $time,
                                     exp_r.gradient, got.gradient);
                        if (got.row_done !== exp_r.row_done)
                            $display("%0t: row_done exp %b got %b", $time,
                                     exp_r.row_done, got.row_done);
                        if (got.row_loss !== exp_r.row_loss)
                            $display("%0t: row_loss exp %0d got %0d", $time,
                                     exp_r.row_loss, got.row_loss);
                        if (got.pred !== exp_r.pred)
                            $display("%0t: predicted_class exp %0d got %0d", $time,
                                     exp_r.pred, got.pred);
                        if (got.correct !== exp_r.correct)
                            $display("%0t: correct exp %b got %b", $time,
                                     exp_r.correct, got.correct);
                        if (got.loss_total !== exp_r.loss_total)
                            $display("%0t: batch_loss_total exp %0d got %0d", $time,
                                     exp_r.loss_total, got.loss_total);
                        if (got.hits !== exp_r.hits)
                            $display("%0t: correct_count exp %0d got %0d", $time,
                                     exp_r.hits, got.hits);
                    end
                end
            end
            if (i_cfg_valid && i_cfg_ready) begin
                if (i_cfg_index == CFG_LOSS_MODE) mode_sh <= i_cfg_data[0];
                else if (i_cfg_index == CFG_NUM_CLASSES) ncls_sh <= i_cfg_data;
            end
            if (i_s_valid && i_s_ready)
                result_q.push_back(predict_score(i_s_data[15:0], i_s_data[23:16],
                                                 i_s_user));
        end
    end

endmodule

[bench/testbench.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Stimulus and verdict for the classifier loss and gradient head.
// ----------------------------------------------------------------------------
// Directed rows hit score extremes, argmax ties, out-of-range labels, both
// loss modes, mid-row mode and class-count changes and clamped class counts.
// Random rows follow in three phases with differing idle patterns; the
// checker beside the block predicts and compares every result item.
// ----------------------------------------------------------------------------
module testbench
    import clh_pkg::*;
();

    localparam int ITEMS_PER_PHASE = 610;

    logic         i_clk = 1'b0;
    logic         i_rst_n = 1'b0;
    logic         cfg_valid = 1'b0;
    logic [7:0]   cfg_index = '0;
    logic [8:0]   cfg_data = '0;
    logic         s_valid = 1'b0;
    logic [23:0]  s_data = '0;
    logic         s_user = 1'b0;
    logic         m_ready = 1'b0;
    logic         cfg_ready;
    logic         s_ready;
    logic         m_valid;
    logic [103:0] m_data;
    logic         m_last;
    int           errors;
    int           pending;

    // idle odds in percent, per phase
    int           send_idle = 0;
    int           recv_idle = 0;
    // shadow of the programmed class count, for shaping rows
    int           row_len = 10;
    logic         cur_mode = 1'b0;
    int           sent;

    always #5 i_clk = ~i_clk;

    classifier_loss_gradient_head dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_valid     (cfg_valid),
        .o_cfg_ready     (cfg_ready),
        .i_cfg_index     (cfg_index),
        .i_cfg_data      (cfg_data),
        .i_s_axis_tvalid (s_valid),
        .o_s_axis_tready (s_ready),
        .i_s_axis_tdata  (s_data),
        .i_s_axis_tuser  (s_user),
        .o_m_axis_tvalid (m_valid),
        .i_m_axis_tready (m_ready),
        .o_m_axis_tdata  (m_data),
        .o_m_axis_tlast  (m_last)
    );

    clh_checker u_checker (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (cfg_valid),
        .i_cfg_ready (cfg_ready),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data),
        .i_s_valid   (s_valid),
        .i_s_ready   (s_ready),
        .i_s_data    (s_data),
        .i_s_user    (s_user),
        .i_m_valid   (m_valid),
        .i_m_ready   (m_ready),
        .i_m_data    (m_data),
        .i_m_last    (m_last),
        .o_errors    (errors),
        .o_pending   (pending)
    );

    // receiver backpressure
    always @(negedge i_clk)
        m_ready <= ($urandom_range(99) >= recv_idle);

    // one score item; valid stays high straight into the next call
    task automatic send_score(int score, int label, bit first);
        @(negedge i_clk);
        while ($urandom_range(99) < send_idle) begin
            s_valid <= 1'b0;
            @(negedge i_clk);
        end
        s_valid <= 1'b1;
        s_data  <= {8'(label), 16'(score)};
        s_user  <= first;
        do @(posedge i_clk); while (!s_ready);
        sent++;
    endtask

    // drain: lower valid, wait out every result plus row-end unit latency
    task automatic settle();
        @(negedge i_clk);
        s_valid <= 1'b0;
        while (pending != 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [7:0] idx, logic [8:0] val);
        @(negedge i_clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge i_clk); while (!cfg_ready);
        @(negedge i_clk);
        cfg_valid <= 1'b0;
        if (idx == CFG_LOSS_MODE) cur_mode = val[0];
        else row_len = (val == 0) ? 1 : (val > 256) ? 256 : int'(val);
    endtask

    // random row: mostly a sensible label, probability-like scores in CE mode
    task automatic random_row();
        int  label;
        int  score;
        bit  first;
        label = ($urandom_range(99) < 85) ? $urandom_range(row_len - 1)
                                          : $urandom_range(255);
        for (int k = 0; k < row_len; k++) begin
            if (cur_mode && $urandom_range(99) < 70)
                score = $urandom_range(4200) - 50;
            else
                score = $urandom_range(65535);
            first = (k == 0) ? ($urandom_range(99) < 12) : ($urandom_range(99) < 3);
            send_score(score, label, first);
        end
    endtask

    task automatic random_config();
        int pick;
        pick = $urandom_range(99);
        write_reg(CFG_LOSS_MODE, 9'($urandom_range(1)));
        if (pick < 4)       write_reg(CFG_NUM_CLASSES, 9'd256);
        else if (pick < 6)  write_reg(CFG_NUM_CLASSES, 9'($urandom_range(511, 257)));
        else if (pick < 10) write_reg(CFG_NUM_CLASSES, 9'd0);
        else                write_reg(CFG_NUM_CLASSES, 9'($urandom_range(16, 1)));
    endtask

    task automatic random_phase(int s_idle, int r_idle);
        int goal;
        send_idle = s_idle;
        recv_idle = r_idle;
        goal = sent + ITEMS_PER_PHASE;
        while (sent < goal) begin
            random_config();
            for (int r = 0; r < 8 && sent < goal; r++) random_row();
            settle();
        end
    endtask

    initial begin
        sent = 0;
        repeat (7) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // ---- directed: one-score rows, field extremes, label out of range
        send_idle = 10;
        recv_idle = 30;
        write_reg(CFG_LOSS_MODE, 9'd0);
        write_reg(CFG_NUM_CLASSES, 9'd1);
        send_score(32767, 0, 1);
        send_score(-32768, 0, 0);
        send_score(0, 255, 0);
        settle();

        // argmax tie: first index wins
        write_reg(CFG_NUM_CLASSES, 9'd3);
        send_score(100, 1, 1);
        send_score(100, 1, 0);
        send_score(-5, 1, 0);
        // mode switched mid-row: last score runs under cross entropy
        send_score(4096, 2, 0);
        send_score(-4096, 2, 0);
        settle();
        write_reg(CFG_LOSS_MODE, 9'd1);
        send_score(300, 2, 0);
        // cross entropy: score at 1.0, tiny score, one LSB, no hot position
        send_score(4096, 0, 0);
        send_score(10, 0, 0);
        send_score(20, 0, 0);
        send_score(-7, 2, 0);
        send_score(1, 2, 0);
        send_score(-200, 2, 0);
        send_score(1, 1, 0);
        send_score(1, 1, 0);
        send_score(1, 1, 0);
        send_score(2000, 7, 0);
        send_score(2000, 7, 0);
        send_score(2000, 7, 0);
        settle();

        // class count lowered mid-row: the next score closes the row
        write_reg(CFG_NUM_CLASSES, 9'd4);
        send_score(900, 1, 1);
        send_score(3000, 1, 0);
        send_score(700, 1, 0);
        settle();
        write_reg(CFG_NUM_CLASSES, 9'd2);
        send_score(50, 1, 0);
        // count of zero acts as one
        settle();
        write_reg(CFG_NUM_CLASSES, 9'd0);
        send_score(2048, 0, 0);
        settle();

        // ---- random phases
        random_phase(19, 68);
        random_phase(68, 19);
        random_phase(0, 0);

        if (errors == 0)
            $display("classifier_loss_gradient_head verification clean");
        else
            $display("classifier_loss_gradient_head verification failed");
        $finish;
    end

    initial begin
        #20ms;
        $display("classifier_loss_gradient_head verification failed");
        $finish;
    end

endmodule

[sim.f]
rtl/clh_pkg.sv
rtl/clh_ctrl.sv
rtl/clh_dp.sv
rtl/classifier_loss_gradient_head.sv
bench/clh_checker.sv
bench/testbench.sv
